// ===== hdl/lsepc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsepc_pkg
// Shared types, constants and helper functions for the LED strip pixel color
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lsepc_pkg;

  // Field widths
  localparam int unsigned ModeW   = 3;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned FrameW  = 11;
  localparam int unsigned PixW    = 8;
  localparam int unsigned LenW    = 9;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned SumW    = 12;

  // Strip and effect geometry
  localparam int unsigned MaxPixels  = 256;
  localparam int unsigned LineLength = 5;

  // Quotient bits of the spread position, one per divider stage
  localparam int unsigned QuoW = 8;

  // Register map
  localparam int unsigned AddrW        = 3;
  localparam logic [AddrW-1:0] AddrStripLength = 3'd0;
  localparam logic [LenW-1:0]  StripLengthRst  = 9'd60;

  // Effect codes
  localparam logic [ModeW-1:0] ModeChase  = 3'd0;
  localparam logic [ModeW-1:0] ModeFill   = 3'd1;
  localparam logic [ModeW-1:0] ModeLine   = 3'd2;
  localparam logic [ModeW-1:0] ModeSplit  = 3'd3;
  localparam logic [ModeW-1:0] ModeWheel  = 3'd4;
  localparam logic [ModeW-1:0] ModeSpread = 3'd5;

  // Item traveling down the pipeline
  typedef struct packed {
    logic              beyond;      // pixel off the strip or unused effect
    logic              wheel;       // color comes from the rainbow wheel
    logic              spread;      // wheel position adds the quotient
    logic              chase_lit;   // chase pattern has this pixel on
    logic [IndexW-1:0] color_index;
    logic [PixW-1:0]   base;        // wheel position before the quotient
    logic [PixW-1:0]   rem;         // divider partial remainder
    logic [QuoW-1:0]   quo;         // divider partial quotient
  } pkt_t;

  // Finished pixel
  typedef struct packed {
    logic              lit;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
  } pix_t;

  // Residue modulo 3: 4 is 1 mod 3, so the 2-bit digits add up
  function automatic logic [1:0] mod3(input logic [SumW-1:0] v);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6])
       + 5'(v[9:8]) + 5'(v[11:10]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
  endfunction

  // Palette lookup as {blue, green, red}; entries past the table are black
  function automatic logic [3*ColorW-1:0] palette(input logic [IndexW-1:0] ci);
    logic [3*ColorW-1:0] c;
    case (ci)
      4'd0:    c = {8'd0,   8'd0,   8'd255};
      4'd1:    c = {8'd0,   8'd255, 8'd0};
      4'd2:    c = {8'd255, 8'd0,   8'd0};
      4'd3:    c = {8'd255, 8'd255, 8'd255};
      4'd4:    c = {8'd0,   8'd255, 8'd255};
      4'd5:    c = {8'd255, 8'd0,   8'd255};
      4'd6:    c = {8'd255, 8'd255, 8'd0};
      4'd7:    c = {8'd0,   8'd128, 8'd255};
      4'd8:    c = {8'd128, 8'd0,   8'd255};
      4'd9:    c = {8'd255, 8'd128, 8'd0};
      4'd10:   c = {8'd0,   8'd64,  8'd128};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lsepc_front.sv =====
// ----------------------------------------------------------------------------
// lsepc_front
// Decode stage: classify the request, evaluate the chase patterns and seed
// the spread divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lsepc_front
  import lsepc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [LenW-1:0]   n_i,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire logic [ModeW-1:0]  mode_i,
  input  wire logic              backward_i,
  input  wire logic [IndexW-1:0] color_index_i,
  input  wire logic [FrameW-1:0] frame_step_i,
  input  wire logic [PixW-1:0]   pixel_index_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output pkt_t                   pkt_o
);

  logic valid_q;
  pkt_t pkt_q, pkt_d;

  logic [SumW-1:0] p12, f12, n12, sum1, len12;
  logic [1:0]      pm3, fm3;
  logic            fwd_line, back_line, f_lt_n;

  // Widen operands and form the shared sums
  always_comb begin
    p12   = SumW'(pixel_index_i);
    f12   = SumW'(frame_step_i);
    n12   = SumW'(n_i);
    len12 = SumW'(LineLength);
    sum1  = p12 + f12 + SumW'(1);
    pm3   = mod3(p12);
    fm3   = mod3(f12);
    f_lt_n    = f12 < n12;
    fwd_line  = (f12 <= p12) && (p12 < f12 + len12);
    // p within [n-1-f, n-1-f+len): shift both sides by f+1
    back_line = f_lt_n && (sum1 >= n12) && (sum1 < n12 + len12);
  end

  // Decode the request into a pipeline item
  always_comb begin
    pkt_d             = '0;
    pkt_d.color_index = color_index_i;
    pkt_d.rem         = pixel_index_i;
    pkt_d.quo         = '0;
    pkt_d.beyond      = ({1'b0, pixel_index_i} >= n_i) || (mode_i > ModeSpread);
    case (mode_i)
      ModeChase: pkt_d.chase_lit = backward_i ? (pm3 == 2'(2'd2 - fm3)) : (pm3 == fm3);
      ModeFill:  pkt_d.chase_lit = backward_i ? (sum1 >= n12) : (p12 <= f12);
      ModeLine:  pkt_d.chase_lit = backward_i ? back_line : fwd_line;
      ModeSplit: pkt_d.chase_lit = fwd_line || back_line;
      ModeWheel: begin
        pkt_d.wheel = 1'b1;
        pkt_d.base  = PixW'(p12 + f12);
      end
      ModeSpread: begin
        pkt_d.wheel  = 1'b1;
        pkt_d.spread = 1'b1;
        pkt_d.base   = frame_step_i[PixW-1:0];
      end
      default: pkt_d.chase_lit = 1'b0;
    endcase
    if (pkt_d.beyond) begin
      pkt_d.wheel     = 1'b0;
      pkt_d.spread    = 1'b0;
      pkt_d.chase_lit = 1'b0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Hold the valid bit until the next stage takes the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture payload on an accepted transfer
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pkt_q <= pkt_d;
    end
  end

  assign valid_o = valid_q;
  assign pkt_o   = pkt_q;

  a_beyond_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && pkt_q.beyond |-> !pkt_q.wheel && !pkt_q.chase_lit)
    else $error("item off the strip still marked for color");

  a_wheel_no_chase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && pkt_q.wheel |-> !pkt_q.chase_lit && pkt_q.quo == '0)
    else $error("wheel item carries chase state");

endmodule

`default_nettype wire

// ===== hdl/lsepc_div_step.sv =====
// ----------------------------------------------------------------------------
// lsepc_div_step
// One restoring division step: produces one quotient bit of
// pixel_index * 256 / strip length per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lsepc_div_step
  import lsepc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [LenW-1:0] n_i,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire pkt_t            pkt_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output pkt_t                 pkt_o
);

  logic            valid_q;
  pkt_t            pkt_q, pkt_d;
  logic [LenW-1:0] rem2;
  logic            ge;

  // Shift in a zero dividend bit, subtract the length when it fits
  always_comb begin
    rem2      = {pkt_i.rem, 1'b0};
    ge        = rem2 >= n_i;
    pkt_d     = pkt_i;
    pkt_d.rem = ge ? PixW'(rem2 - n_i) : rem2[PixW-1:0];
    pkt_d.quo = {pkt_i.quo[QuoW-2:0], ge};
  end

  assign ready_o = !valid_q || ready_i;

  // Hold the valid bit until the next stage takes the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture payload on an accepted transfer
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pkt_q <= pkt_d;
    end
  end

  assign valid_o = valid_q;
  assign pkt_o   = pkt_q;

endmodule

`default_nettype wire

// ===== hdl/lsepc_color.sv =====
// ----------------------------------------------------------------------------
// lsepc_color
// Output stage: rainbow wheel and palette lookup, registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module lsepc_color
  import lsepc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire pkt_t pkt_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output pix_t      pix_o
);

  logic              valid_q;
  pix_t              pix_q, pix_d;
  logic [PixW-1:0]   pos, w, w3;
  logic [3*ColorW-1:0] pal;

  // Rainbow wheel on the inverted position, three segments split at 85 and 170
  always_comb begin
    pos = pkt_i.base + (pkt_i.spread ? pkt_i.quo : '0);
    w   = ~pos;
    if (w < 8'd85) begin
      w3 = PixW'({w, 1'b0} + {1'b0, w});
    end else if (w < 8'd170) begin
      w3 = PixW'({w - 8'd85, 1'b0} + {1'b0, w - 8'd85});
    end else begin
      w3 = PixW'({w - 8'd170, 1'b0} + {1'b0, w - 8'd170});
    end
    pal = palette(pkt_i.color_index);

    pix_d = '0;
    if (pkt_i.wheel) begin
      pix_d.lit = 1'b1;
      if (w < 8'd85) begin
        pix_d.red  = 8'd255 - w3;
        pix_d.blue = w3;
      end else if (w < 8'd170) begin
        pix_d.green = w3;
        pix_d.blue  = 8'd255 - w3;
      end else begin
        pix_d.red   = w3;
        pix_d.green = 8'd255 - w3;
      end
    end else if (pkt_i.chase_lit) begin
      pix_d.lit   = 1'b1;
      pix_d.red   = pal[ColorW-1:0];
      pix_d.green = pal[2*ColorW-1:ColorW];
      pix_d.blue  = pal[3*ColorW-1:2*ColorW];
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Hold the result until the sink takes the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

`default_nettype wire

// ===== hdl/led_strip_effect_pixel_color.sv =====
// ----------------------------------------------------------------------------
// led_strip_effect_pixel_color
// Pixel color generator for LED strip chase and rainbow effects.
// ----------------------------------------------------------------------------
// One request enters per clock while the output is not stalled and passes a decode
// stage, eight divider stages that each resolve one bit of the spread-wheel
// position pixel_index * 256 / strip_length, and a color stage that holds the
// result. Sustained rate is one pixel per cycle; every stage has its own valid
// bit, so a stalled output only backs up as far as the pipeline is full.
// strip_length may only be written while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module led_strip_effect_pixel_color
  import lsepc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Request stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // [2:0] mode, [3] backward, [7:4] color_index, [18:8] frame_step,
  // [26:19] pixel_index, [31:27] zero
  input  wire logic [31:0]       s_axis_tdata,
  // Result stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [24] lit, [31:25] zero
  output logic [31:0]            m_axis_tdata,
  // Register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [LenW-1:0] strip_length_q;
  logic [LenW-1:0] n;

  // Register write and readback
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_length_q <= StripLengthRst;
    end else if (psel && penable && pwrite && pready && paddr == AddrStripLength) begin
      strip_length_q <= pwdata[LenW-1:0];
    end
  end

  assign prdata = (paddr == AddrStripLength) ? 32'(strip_length_q) : '0;

  // Cap the length at the largest supported strip
  assign n = (strip_length_q > LenW'(MaxPixels)) ? LenW'(MaxPixels) : strip_length_q;

  // Pipeline stage links: 0 after decode, QuoW after the last divider step
  logic [QuoW:0] valid;
  logic [QuoW:0] ready;
  pkt_t          pkt [QuoW+1];
  pix_t          pix;

  lsepc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_i           (n),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .mode_i        (s_axis_tdata[2:0]),
    .backward_i    (s_axis_tdata[3]),
    .color_index_i (s_axis_tdata[7:4]),
    .frame_step_i  (s_axis_tdata[18:8]),
    .pixel_index_i (s_axis_tdata[26:19]),
    .valid_o       (valid[0]),
    .ready_i       (ready[0]),
    .pkt_o         (pkt[0])
  );

  for (genvar i = 0; i < QuoW; i++) begin : g_div
    lsepc_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .n_i     (n),
      .valid_i (valid[i]),
      .ready_o (ready[i]),
      .pkt_i   (pkt[i]),
      .valid_o (valid[i+1]),
      .ready_i (ready[i+1]),
      .pkt_o   (pkt[i+1])
    );
  end

  lsepc_color u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[QuoW]),
    .ready_o (ready[QuoW]),
    .pkt_i   (pkt[QuoW]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .pix_o   (pix)
  );

  assign m_axis_tdata = {7'd0, pix.lit, pix.blue, pix.green, pix.red};

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && (&valid))
    else $error("request refused while pipeline has room");

  a_dark_when_unlit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !pix.lit |-> pix.red == '0 && pix.green == '0 && pix.blue == '0)
    else $error("unlit pixel carries color");

endmodule

`default_nettype wire
